// ===== src/usd_pkg.sv =====
// ----------------------------------------------------------------------------
// usd_pkg
// Shared types and codes for the byte stream to 16-bit character decoder.
// ----------------------------------------------------------------------------
package usd_pkg;

  // encoding_mode codes (5 to 7 decode as utf-8)
  localparam logic [2:0] MODE_UTF8  = 3'd0;
  localparam logic [2:0] MODE_U16LE = 3'd1;
  localparam logic [2:0] MODE_U16BE = 3'd2;
  localparam logic [2:0] MODE_U32LE = 3'd3;
  localparam logic [2:0] MODE_U32BE = 3'd4;

  // result_kind codes
  localparam logic [1:0] KIND_CHAR    = 2'd0;
  localparam logic [1:0] KIND_DROPPED = 2'd1;
  localparam logic [1:0] KIND_SHORT   = 2'd2;

  localparam logic [15:0] CHAR_STRAY   = 16'h003F;  // '?'
  localparam logic [15:0] CHAR_REPLACE = 16'hFFFD;

  typedef struct packed {
    logic [15:0] acc;        // utf-8 code point being built
    logic [2:0]  remaining;  // utf-8 continuation bytes still expected
    logic [23:0] assembler;  // earlier bytes of a utf-16/utf-32 unit
    logic [1:0]  phase;      // bytes of the current unit already held
  } stream_state_t;

  typedef struct packed {
    logic        emit;
    logic [15:0] ch;
    logic [1:0]  kind;
    logic        last;
  } step_result_t;

endpackage

// ===== src/usd_decode_core.sv =====
// ----------------------------------------------------------------------------
// usd_decode_core
// Next-state and result logic for one byte of the stream.
// ----------------------------------------------------------------------------
module usd_decode_core
  import usd_pkg::*;
(
  input  logic [2:0]    mode,
  input  stream_state_t state,
  input  logic [7:0]    byte_in,
  input  logic          stream_end,
  output stream_state_t state_nxt,
  output step_result_t  result
);

  logic        unit_mode;
  logic        is16;
  logic        unit_done;
  logic [2:0]  rem_dec;
  logic [15:0] cont_add;
  logic [15:0] acc_sum;
  logic [2:0]  lead_n;
  logic [15:0] lead_acc;
  logic [7:0]  b0, b1, b2;
  logic [15:0] unit_ch;

  assign unit_mode = (mode == MODE_U16LE) || (mode == MODE_U16BE) ||
                     (mode == MODE_U32LE) || (mode == MODE_U32BE);
  assign is16      = (mode == MODE_U16LE) || (mode == MODE_U16BE);
  assign unit_done = is16 ? (state.phase >= 2'd1) : (state.phase == 2'd3);

  assign b0 = state.assembler[7:0];
  assign b1 = state.assembler[15:8];
  assign b2 = state.assembler[23:16];

  // continuation byte payload placed by the count still to come
  assign rem_dec = state.remaining - 3'd1;
  always_comb begin
    case (rem_dec)
      3'd0:    cont_add = {10'd0, byte_in[5:0]};
      3'd1:    cont_add = {4'd0, byte_in[5:0], 6'd0};
      3'd2:    cont_add = {byte_in[3:0], 12'd0};
      default: cont_add = 16'd0;
    endcase
  end
  assign acc_sum = state.acc + cont_add;

  // continuation bytes announced by a lead byte (its leading ones less one)
  always_comb begin
    if (byte_in[7:5] == 3'b110) begin
      lead_n = 3'd1;
    end else if (byte_in[7:4] == 4'b1110) begin
      lead_n = 3'd2;
    end else if (byte_in[7:3] == 5'b11110) begin
      lead_n = 3'd3;
    end else if (byte_in[7:2] == 6'b111110) begin
      lead_n = 3'd4;
    end else if (byte_in[7:1] == 7'b1111110) begin
      lead_n = 3'd5;
    end else if (byte_in == 8'hFE) begin
      lead_n = 3'd6;
    end else if (byte_in == 8'hFF) begin
      lead_n = 3'd7;
    end else begin
      lead_n = 3'd0;
    end
  end

  always_comb begin
    case (lead_n)
      3'd1:    lead_acc = {5'd0, byte_in[4:0], 6'd0};
      3'd2:    lead_acc = {byte_in[3:0], 12'd0};
      default: lead_acc = 16'd0;
    endcase
  end

  always_comb begin
    case (mode)
      MODE_U16LE: unit_ch = {byte_in, b0};
      MODE_U16BE: unit_ch = {b0, byte_in};
      MODE_U32LE: unit_ch = (b2 != 8'd0 || byte_in != 8'd0) ? CHAR_REPLACE : {b1, b0};
      MODE_U32BE: unit_ch = (b0 != 8'd0 || b1 != 8'd0) ? CHAR_REPLACE : {b2, byte_in};
      default:    unit_ch = 16'd0;
    endcase
  end

  always_comb begin
    state_nxt   = state;
    result      = '0;
    result.last = stream_end;
    if (unit_mode) begin
      if (!unit_done) begin
        case (state.phase)
          2'd0:    state_nxt.assembler[7:0]   = byte_in;
          2'd1:    state_nxt.assembler[15:8]  = byte_in;
          2'd2:    state_nxt.assembler[23:16] = byte_in;
          default: state_nxt.assembler        = state.assembler;
        endcase
        state_nxt.phase = state.phase + 2'd1;
        result.emit = stream_end;
        result.kind = KIND_DROPPED;
      end else begin
        state_nxt.assembler = '0;
        state_nxt.phase     = 2'd0;
        result.emit = 1'b1;
        result.ch   = unit_ch;
        result.kind = KIND_CHAR;
      end
    end else if (state.remaining != 3'd0) begin
      state_nxt.remaining = rem_dec;
      if (rem_dec == 3'd0) begin
        state_nxt.acc = 16'd0;
        result.emit = 1'b1;
        result.ch   = acc_sum;
        result.kind = KIND_CHAR;
      end else begin
        state_nxt.acc = acc_sum;
        result.emit = stream_end;
        result.ch   = acc_sum;
        result.kind = KIND_SHORT;
      end
    end else if (!byte_in[7]) begin
      result.emit = 1'b1;
      result.ch   = {8'd0, byte_in};
    end else if (!byte_in[6]) begin
      result.emit = 1'b1;
      result.ch   = CHAR_STRAY;
    end else begin
      state_nxt.acc       = lead_acc;
      state_nxt.remaining = lead_n;
      result.emit = stream_end;
      result.ch   = lead_acc;
      result.kind = KIND_SHORT;
    end
    // the final byte of a stream always restarts decoding
    if (stream_end) begin
      state_nxt = '0;
    end
  end

endmodule

// ===== src/unicode_stream_to_utf16_decoder.sv =====
// ----------------------------------------------------------------------------
// unicode_stream_to_utf16_decoder
// Byte stream (utf-8, utf-16 le/be, utf-32 le/be) to 16-bit characters.
// ----------------------------------------------------------------------------
// Unless stalled, one byte beat goes in per cycle and at most one character
// beat comes out in the cycle after its last byte. Throughput is one byte per
// clock: the decode is a single pass of shifts and masks between the stream
// state registers and the output register, and a byte is accepted whenever
// the output register is empty or being drained in the same cycle. utf-8 is
// decoded leniently: a stray continuation byte gives '?', a lead byte's
// leading ones set how many bytes follow with no check on them, and the code
// point is kept modulo 2^16. utf-32 values above 0xFFFF become 0xFFFD. A
// byte flagged as stream end always yields exactly one beat with last set:
// a dropped partial unit shows as char 0 with kind 1, a cut-short utf-8
// sequence as the value so far with kind 2. Writing encoding_mode clears the
// stream state; write it only while the block is idle.
module unicode_stream_to_utf16_decoder
  import usd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_write_en,
  input  logic [2:0]  cfg_encoding_mode,
  // byte input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte_in,
  input  logic        in_stream_end,
  // character output
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_char_out,
  output logic [1:0]  out_result_kind,
  output logic        out_last_out
);

  logic [2:0]    mode_r;
  stream_state_t state_r;
  stream_state_t state_nxt;
  step_result_t  step_res;
  logic          in_accept;

  logic          out_valid_r;
  logic [15:0]   char_r;
  logic [1:0]    kind_r;
  logic          last_r;

  // take a byte whenever the output register is free or draining
  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;

  usd_decode_core u_core (
    .mode       (mode_r),
    .state      (state_r),
    .byte_in    (in_byte_in),
    .stream_end (in_stream_end),
    .state_nxt  (state_nxt),
    .result     (step_res)
  );

  // mode register and stream state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_UTF8;
      state_r <= '0;
    end else if (cfg_write_en) begin
      // new mode abandons anything in progress
      mode_r  <= cfg_encoding_mode;
      state_r <= '0;
    end else if (in_accept) begin
      state_r <= state_nxt;
    end
  end

  // output beat valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= step_res.emit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output payload, loaded only with a new beat
  always_ff @(posedge clk) begin
    if (in_accept && step_res.emit) begin
      char_r <= step_res.ch;
      kind_r <= step_res.kind;
      last_r <= step_res.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_char_out    = char_r;
  assign out_result_kind = kind_r;
  assign out_last_out    = last_r;

endmodule

// ===== src/usd_checker.sv =====
// ----------------------------------------------------------------------------
// usd_checker
// Port-level checks for the byte stream decoder, bound to the top level.
// ----------------------------------------------------------------------------
module usd_checker
  import usd_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_stream_end,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_char_out,
  input logic [1:0]  out_result_kind,
  input logic        out_last_out
);

  // a stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_char_out) && $stable(out_result_kind) &&
      $stable(out_last_out))
    else $error("output beat changed while stalled");

  // empty output register never blocks input
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with output register empty");

  // every end byte gives a last beat next cycle
  a_end_gives_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_stream_end |=> out_valid && out_last_out)
    else $error("stream end byte did not produce a last beat");

  // flagged kinds only close a stream
  a_flag_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind != KIND_CHAR |-> out_last_out)
    else $error("flagged result without last");

  // dropped-unit marker carries no character
  a_dropped_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_DROPPED |-> out_char_out == 16'd0)
    else $error("dropped-unit marker with nonzero character");

endmodule

bind unicode_stream_to_utf16_decoder usd_checker u_usd_checker (.*);
